### design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes for the lifo stack with value search.
// ----------------------------------------------------------------------------
package lss_pkg;

	// request operations; codes five to seven are ignored
	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_TOP    = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_INDEX = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam int unsigned FIELD_DATA_W  = 32;
	localparam int unsigned FIELD_INDEX_W = 6;
	localparam int unsigned FIELD_FILL_W  = 7;

	typedef struct packed {
		logic [2:0]               opcode;
		logic [FIELD_DATA_W-1:0]  data_value;
		logic [FIELD_INDEX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [FIELD_DATA_W-1:0] result_value;
		logic                    found;
		logic [1:0]              status;
		logic [FIELD_FILL_W-1:0] fill_count;
	} rsp_t;

endpackage

### design/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// Operation sequencer: fill count, entry store, and one shared equality
// compare that walks the store entry by entry during a search.
// ----------------------------------------------------------------------------
module lss_ctrl #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned DATA_WIDTH  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  lss_pkg::req_t req,
	output logic         idle,
	output logic         done,
	input  logic         take,
	output lss_pkg::rsp_t rsp
);

	import lss_pkg::*;

	localparam int unsigned AW    = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > FIELD_INDEX_W) ? CNT_W : FIELD_INDEX_W;
	localparam int unsigned FX_W  = (CNT_W > FIELD_FILL_W) ? CNT_W : FIELD_FILL_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_READ = 5'b00100,
		S_SCAN = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [2:0]               op_q;
	logic [DATA_WIDTH-1:0]    key_q;
	logic [FIELD_INDEX_W-1:0] idx_q;
	logic [AW-1:0]            ptr_q;
	logic [FIELD_DATA_W-1:0]  value_q;
	logic                     found_q;
	status_t                  status_q;

	logic [63:0]           din_wide;
	logic [63:0]           rd_wide;
	logic                  we;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  full;
	logic                  empty;
	logic [CNT_W-1:0]      cnt_m1;
	logic [CMP_W-1:0]      look_diff;
	logic                  idx_oob;
	logic [AW-1:0]         ptr_next;
	logic                  scan_last;
	logic                  hit;
	logic [FX_W-1:0]       fill_ext;

	// input bits above the store width are dropped, a narrower input is zero extended
	assign din_wide  = 64'(req.data_value);
	assign rd_wide   = 64'(rdata);

	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign empty     = (count_q == '0);
	assign cnt_m1    = count_q - CNT_W'(1);
	assign look_diff = CMP_W'(cnt_m1) - CMP_W'(idx_q);
	assign idx_oob   = (CMP_W'(idx_q) >= CMP_W'(count_q));
	assign ptr_next  = ptr_q + AW'(1);
	assign scan_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign hit       = (rdata == key_q);

	always_comb begin
		we    = 1'b0;
		raddr = ptr_next;
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_PUSH:   we    = !full;
				OP_POP:    raddr = cnt_m1[AW-1:0];
				OP_TOP:    raddr = cnt_m1[AW-1:0];
				OP_LOOKUP: raddr = look_diff[AW-1:0];
				OP_SEARCH: raddr = '0;
				default:   raddr = ptr_next;
			endcase
		end
	end

	lss_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (op_q)
						OP_PUSH: begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_DONE;
						end
						OP_POP: begin
							if (empty) begin
								state_q <= S_DONE;
							end else begin
								count_q <= cnt_m1;
								state_q <= S_READ;
							end
						end
						OP_TOP: state_q <= empty ? S_DONE : S_READ;
						OP_LOOKUP: state_q <= (empty || idx_oob) ? S_DONE : S_READ;
						OP_SEARCH: state_q <= empty ? S_DONE : S_SCAN;
						default: state_q <= S_DONE;
					endcase
				end
				S_READ: state_q <= S_DONE;
				S_SCAN: begin
					if (hit || scan_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= req.opcode;
					key_q    <= din_wide[DATA_WIDTH-1:0];
					idx_q    <= req.entry_index;
					value_q  <= '0;
					found_q  <= 1'b0;
					status_q <= ST_OK;
				end
			end
			S_EXEC: begin
				ptr_q <= '0;
				case (op_q)
					OP_PUSH: begin
						if (full) begin
							status_q <= ST_FULL;
						end
					end
					OP_POP, OP_TOP: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end
					end
					OP_LOOKUP: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end else if (idx_oob) begin
							status_q <= ST_INDEX;
						end
					end
					default: status_q <= ST_OK;
				endcase
			end
			S_READ: value_q <= rd_wide[FIELD_DATA_W-1:0];
			S_SCAN: begin
				if (hit) begin
					found_q <= 1'b1;
				end
				ptr_q <= ptr_next;
			end
			default: ptr_q <= ptr_q;
		endcase
	end

	assign fill_ext = FX_W'(count_q);

	assign idle             = (state_q == S_IDLE);
	assign done             = (state_q == S_DONE);
	assign rsp.result_value = value_q;
	assign rsp.found        = found_q;
	assign rsp.status       = status_q;
	assign rsp.fill_count   = fill_ext[FIELD_FILL_W-1:0];

endmodule

### design/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded last-in-first-out store with push, pop, top, lookup by depth and
// search for an equal value. One result transaction per request transaction.
// ----------------------------------------------------------------------------
//  channel | signals                      | dir | moves
//  --------+------------------------------+-----+------------------------------
//  req     | req_valid, req_stall, req    | in  | opcode, data_value, entry_index
//  rsp     | rsp_valid, rsp_stall, rsp    | out | result_value, found, status,
//          |                              |     | fill_count
//
//  push, unused codes and every error go from the execute state straight to
//  done; pop, top and lookup that read an entry pass the read state first (one
//  registered read of the entry store); search scans until a match or the last
//  stored entry, one stored entry per cycle through the single compare unit.
//  reset clears the fill count and the control state; the entry store is not
//  cleared, only written entries are ever read.
//  one request is in work at a time; a result waiting in the output register
//  under rsp_stall does not block the next request, only its completion.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned DATA_WIDTH  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lss_pkg::rsp_t rsp
);

	import lss_pkg::*;

	logic start;
	logic ctrl_idle;
	logic ctrl_done;
	logic take;
	rsp_t ctrl_rsp;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign req_stall = !ctrl_idle;
	assign start     = req_valid && ctrl_idle;
	// result moves into the output register when it is empty or being drained
	assign take      = ctrl_done && (!rsp_valid_q || !rsp_stall);

	lss_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.idle   (ctrl_idle),
		.done   (ctrl_done),
		.take   (take),
		.rsp    (ctrl_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !ctrl_idle)
		else $error("sequencer still idle after a request transaction");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("finished result not presented");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		take && (ctrl_rsp.status != ST_OK) |->
			(ctrl_rsp.result_value == '0) && !ctrl_rsp.found)
		else $error("error result carries a value or a match");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |-> !take)
		else $error("output register overwritten while stalled");

endmodule
